FILE: design/ppwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppwl_pkg
// Types and constants shared by the positional PID unit.
// ----------------------------------------------------------------------------
package ppwl_pkg;

   localparam int InW      = 16;
   localparam int GainW    = 16;
   localparam int ErrW     = 17;
   localparam int DiffW    = 18;
   localparam int SumW     = 32;
   localparam int DriveW   = 32;
   localparam int CsrW     = 32;
   localparam int CsrAddrW = 3;
   localparam int ModeW    = 3;
   localparam int FracBits = 8;
   localparam int ProdPW   = GainW + ErrW;
   localparam int ProdIW   = GainW + SumW;
   localparam int ProdDW   = GainW + DiffW;
   localparam int AccW     = ProdIW + 1;
   localparam int ShW      = AccW - FracBits;

   // Proportional gain after reset is -2.0 in Q8.8.
   localparam logic signed [GainW-1:0] GainPReset = -16'sd512;

   typedef enum logic [CsrAddrW-1:0] {
      REG_GAIN_P       = 3'd0,
      REG_GAIN_I       = 3'd1,
      REG_GAIN_D       = 3'd2,
      REG_INTEGRAL_MAX = 3'd3,
      REG_INTEGRAL_MIN = 3'd4,
      REG_DRIVE_MAX    = 3'd5,
      REG_DRIVE_MIN    = 3'd6,
      REG_MODE_BITS    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [GainW-1:0]  gain_p;
      logic signed [GainW-1:0]  gain_i;
      logic signed [GainW-1:0]  gain_d;
      logic signed [SumW-1:0]   integral_max;
      logic signed [SumW-1:0]   integral_min;
      logic signed [DriveW-1:0] drive_max;
      logic signed [DriveW-1:0] drive_min;
      logic                     drive_clamp_en;
      logic                     integral_clamp_en;
      logic                     integral_en;
   } cfg_type;

   typedef struct packed {
      logic signed [ErrW-1:0]  err;
      logic signed [SumW-1:0]  sum;
      logic signed [DiffW-1:0] diff;
   } terms_type;

   typedef struct packed {
      logic signed [ProdPW-1:0] prod_p;
      logic signed [ProdIW-1:0] prod_i;
      logic signed [ProdDW-1:0] prod_d;
   } prod_type;

endpackage

FILE: design/ppwl_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppwl_csr
// Configuration registers: gains, integral and drive limits, mode bits.
// ----------------------------------------------------------------------------
module ppwl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ppwl_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [ppwl_pkg::CsrW-1:0]     csr_wdata,
   output ppwl_pkg::cfg_type             cfg
);
   import ppwl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_GAIN_P:       cfg_in.gain_p       = csr_wdata[GainW-1:0];
            REG_GAIN_I:       cfg_in.gain_i       = csr_wdata[GainW-1:0];
            REG_GAIN_D:       cfg_in.gain_d       = csr_wdata[GainW-1:0];
            REG_INTEGRAL_MAX: cfg_in.integral_max = csr_wdata[SumW-1:0];
            REG_INTEGRAL_MIN: cfg_in.integral_min = csr_wdata[SumW-1:0];
            REG_DRIVE_MAX:    cfg_in.drive_max    = csr_wdata[DriveW-1:0];
            REG_DRIVE_MIN:    cfg_in.drive_min    = csr_wdata[DriveW-1:0];
            REG_MODE_BITS: begin
               cfg_in.integral_en       = csr_wdata[0];
               cfg_in.integral_clamp_en = csr_wdata[1];
               cfg_in.drive_clamp_en    = csr_wdata[2];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gain_p: GainPReset, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/ppwl_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppwl_state
// Error, integral and derivative stage holding the controller state.
// ----------------------------------------------------------------------------
module ppwl_state (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic signed [ppwl_pkg::InW-1:0] measured,
   input  logic signed [ppwl_pkg::InW-1:0] target,
   input  ppwl_pkg::cfg_type               cfg,
   output ppwl_pkg::terms_type             terms
);
   import ppwl_pkg::*;

   // err_ff doubles as the previous error for the next transaction.
   logic signed [ErrW-1:0]  err_ff;
   logic signed [ErrW-1:0]  err_in;
   logic signed [SumW-1:0]  sum_ff;
   logic signed [SumW-1:0]  sum_in;
   logic signed [DiffW-1:0] diff_ff;
   logic signed [DiffW-1:0] diff_in;
   logic signed [SumW:0]    sum_wide;
   logic signed [SumW-1:0]  sum_sat;

   always_comb begin
      err_in   = {target[InW-1], target} - {measured[InW-1], measured};
      diff_in  = {err_in[ErrW-1], err_in} - {err_ff[ErrW-1], err_ff};
      sum_wide = {sum_ff[SumW-1], sum_ff}
               + {{(SumW + 1 - ErrW){err_in[ErrW-1]}}, err_in};
      if (sum_wide[SumW] != sum_wide[SumW-1]) begin
         sum_sat = {sum_wide[SumW], {(SumW - 1){~sum_wide[SumW]}}};
      end else begin
         sum_sat = sum_wide[SumW-1:0];
      end
      sum_in = sum_sat;
      if (cfg.integral_clamp_en) begin
         if (sum_sat >= $signed(cfg.integral_max)) begin
            sum_in = cfg.integral_max;
         end else if (sum_sat <= $signed(cfg.integral_min)) begin
            sum_in = cfg.integral_min;
         end
      end
      if (!cfg.integral_en) begin
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
         sum_ff <= '0;
      end else if (enable) begin
         err_ff <= err_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff <= diff_in;
      end
   end

   assign terms.err  = err_ff;
   assign terms.sum  = sum_ff;
   assign terms.diff = diff_ff;

   a_sum_zero: assert property (@(posedge clock) disable iff (reset)
      enable && !cfg.integral_en |=> sum_ff == '0)
      else $error("integral not cleared while disabled");

   a_sum_clamp: assert property (@(posedge clock) disable iff (reset)
      enable && cfg.integral_en && cfg.integral_clamp_en |=>
         (sum_ff <= $signed($past(cfg.integral_max))) ||
         (sum_ff == $past(cfg.integral_min)))
      else $error("integral outside its limits");

endmodule

FILE: design/ppwl_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppwl_mult
// Three parallel gain multiplications with registered products.
// ----------------------------------------------------------------------------
module ppwl_mult (
   input  logic                clock,
   input  logic                enable,
   input  ppwl_pkg::terms_type terms,
   input  ppwl_pkg::cfg_type   cfg,
   output ppwl_pkg::prod_type  prods
);
   import ppwl_pkg::*;

   prod_type prods_ff;
   prod_type prods_in;

   always_comb begin
      prods_in.prod_p = ProdPW'($signed(cfg.gain_p)) * ProdPW'($signed(terms.err));
      prods_in.prod_i = ProdIW'($signed(cfg.gain_i)) * ProdIW'($signed(terms.sum));
      prods_in.prod_d = ProdDW'($signed(cfg.gain_d)) * ProdDW'($signed(terms.diff));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prods_ff <= prods_in;
      end
   end

   assign prods = prods_ff;

endmodule

FILE: design/ppwl_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppwl_out
// Sum of the products, Q8.8 scaling, drive clamp and 32-bit saturation.
// ----------------------------------------------------------------------------
module ppwl_out (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  ppwl_pkg::prod_type                 prods,
   input  ppwl_pkg::cfg_type                  cfg,
   output logic signed [ppwl_pkg::DriveW-1:0] drive
);
   import ppwl_pkg::*;

   logic signed [AccW-1:0]   acc;
   logic signed [ShW-1:0]    scaled;
   logic signed [ShW-1:0]    clamped;
   logic signed [DriveW-1:0] drive_in;
   logic signed [DriveW-1:0] drive_ff;

   always_comb begin
      acc = {{(AccW - ProdPW){prods.prod_p[ProdPW-1]}}, prods.prod_p}
          + {{(AccW - ProdIW){prods.prod_i[ProdIW-1]}}, prods.prod_i}
          + {{(AccW - ProdDW){prods.prod_d[ProdDW-1]}}, prods.prod_d};
      // Dropping the fraction bits rounds toward minus infinity.
      scaled  = acc[AccW-1:FracBits];
      clamped = scaled;
      if (cfg.drive_clamp_en) begin
         if (scaled >= $signed({{(ShW - DriveW){cfg.drive_max[DriveW-1]}},
                                cfg.drive_max})) begin
            clamped = {{(ShW - DriveW){cfg.drive_max[DriveW-1]}}, cfg.drive_max};
         end else if (scaled <= $signed({{(ShW - DriveW){cfg.drive_min[DriveW-1]}},
                                         cfg.drive_min})) begin
            clamped = {{(ShW - DriveW){cfg.drive_min[DriveW-1]}}, cfg.drive_min};
         end
      end
      if ((&clamped[ShW-1:DriveW-1]) || !(|clamped[ShW-1:DriveW-1])) begin
         drive_in = clamped[DriveW-1:0];
      end else begin
         drive_in = {clamped[ShW-1], {(DriveW - 1){~clamped[ShW-1]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;

   a_drive_clamp: assert property (@(posedge clock) disable iff (reset)
      enable && cfg.drive_clamp_en |=>
         (drive_ff <= $signed($past(cfg.drive_max))) ||
         (drive_ff == $past(cfg.drive_min)))
      else $error("drive outside its limits");

endmodule

FILE: design/positional_pid_with_limits_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_pid_with_limits_unit
// Positional PID controller step with optional integral and drive limits.
// ----------------------------------------------------------------------------
// Each req transaction carries a measured value and a target; each produces
// exactly one rsp transaction carrying the drive, in order.
// The csr port writes gains, limits and mode bits; write it only while no
// transaction is in flight.
// Pipeline: input register, error/integral stage, multiply stage and
// result register; the drive of an accepted req transaction passes
// through them in that order to rsp. One transaction can be taken every
// cycle while rsp_tready does not hold the pipeline. The integral and
// previous error update in the error stage, closing the only feedback loop.
// When rsp_tready is low the pipeline holds and req_tready falls once all
// four registers are full; nothing is dropped.
// Reset clears the pipeline, the integral and the previous error, and
// restores the registers to their defaults (proportional gain -2.0).
// ----------------------------------------------------------------------------
module positional_pid_with_limits_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // measured[15:0], target[31:16]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,  // drive[31:0]
   input  logic                          csr_we,
   input  logic [ppwl_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [ppwl_pkg::CsrW-1:0]     csr_wdata
);
   import ppwl_pkg::*;

   cfg_type   cfg;
   terms_type terms;
   prod_type  prods;

   logic signed [InW-1:0]    measured_ff;
   logic signed [InW-1:0]    target_ff;
   logic signed [DriveW-1:0] drive;

   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s0_ready, s1_ready, s2_ready, s3_ready;
   logic s0_move, s1_move, s2_move, req_take;

   always_comb begin
      s3_ready = !rsp_valid_ff || rsp_tready;
      s2_ready = !s2_valid_ff || s3_ready;
      s1_ready = !s1_valid_ff || s2_ready;
      s0_ready = !s0_valid_ff || s1_ready;
      s2_move  = s2_valid_ff && s3_ready;
      s1_move  = s1_valid_ff && s2_ready;
      s0_move  = s0_valid_ff && s1_ready;
      req_take = req_tvalid && s0_ready;

      s0_valid_in  = req_take ? 1'b1 : (s1_ready ? 1'b0 : s0_valid_ff);
      s1_valid_in  = s0_move  ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_move  ? 1'b1 : (s3_ready ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_move  ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         measured_ff <= req_tdata[InW-1:0];
         target_ff   <= req_tdata[2*InW-1:InW];
      end
   end

   ppwl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppwl_state u_state (
      .clock    (clock),
      .reset    (reset),
      .enable   (s0_move),
      .measured (measured_ff),
      .target   (target_ff),
      .cfg      (cfg),
      .terms    (terms)
   );

   ppwl_mult u_mult (
      .clock  (clock),
      .enable (s1_move),
      .terms  (terms),
      .cfg    (cfg),
      .prods  (prods)
   );

   ppwl_out u_out (
      .clock  (clock),
      .reset  (reset),
      .enable (s2_move),
      .prods  (prods),
      .cfg    (cfg),
      .drive  (drive)
   );

   assign req_tready = s0_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive;

   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s0_valid_ff)
      else $error("accepted transaction not held in the input register");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result raised without a product in flight");

endmodule
